// File: design/gnmc_pkg.sv
// ----------------------------------------------------------------------------
// gnmc_pkg
// Shared widths and constants for the grid neighbor mine count block.
// ----------------------------------------------------------------------------
`default_nettype none

package gnmc_pkg;

  localparam int CFG_W       = 6;   // cols_in_use register
  localparam int ROW_W       = 32;  // row_bits on the input stream
  localparam int VALUE_W     = 4;   // cell_value
  localparam int COLUMN_W    = 5;   // column
  localparam int OUT_TDATA_W = 16;  // cell_value and column, padded to bytes
  localparam int QUEUE_DEPTH = 4;   // row jobs waiting for the emitter
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_W-1:0]   COLS_RESET = CFG_W'(32);
  localparam logic [VALUE_W-1:0] MINE_VALUE = VALUE_W'(9);

endpackage

`default_nettype wire

// File: design/gnmc_lane.sv
// ----------------------------------------------------------------------------
// gnmc_lane
// One column lane: neighbor count from three 3-bit windows, or the mine code.
// ----------------------------------------------------------------------------
`default_nettype none

module gnmc_lane (
  input  wire logic [2:0]                      above,
  input  wire logic [2:0]                      mid,
  input  wire logic [2:0]                      below,
  output logic      [gnmc_pkg::VALUE_W-1:0]    value
);

  logic [gnmc_pkg::VALUE_W-1:0] count;

  always_comb begin
    count = gnmc_pkg::VALUE_W'(above[0]) + gnmc_pkg::VALUE_W'(above[1])
          + gnmc_pkg::VALUE_W'(above[2]) + gnmc_pkg::VALUE_W'(mid[0])
          + gnmc_pkg::VALUE_W'(mid[2])   + gnmc_pkg::VALUE_W'(below[0])
          + gnmc_pkg::VALUE_W'(below[1]) + gnmc_pkg::VALUE_W'(below[2]);
    value = mid[1] ? gnmc_pkg::MINE_VALUE : count;
  end

endmodule

`default_nettype wire

// File: design/gnmc_job_queue.sv
// ----------------------------------------------------------------------------
// gnmc_job_queue
// Small queue of row jobs; takes up to two jobs per cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module gnmc_job_queue #(
  parameter int WIDTH = 104
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push0,
  input  wire logic [WIDTH-1:0] push0_data,
  input  wire logic             push1,
  input  wire logic [WIDTH-1:0] push1_data,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic      [WIDTH-1:0] head_data,
  output logic                  room_for_two
);

  logic [WIDTH-1:0]                entries [gnmc_pkg::QUEUE_DEPTH];
  logic [gnmc_pkg::QPTR_W-1:0]     wr_ptr;
  logic [gnmc_pkg::QPTR_W-1:0]     rd_ptr;
  logic [gnmc_pkg::QCNT_W-1:0]     count;
  logic [gnmc_pkg::QPTR_W-1:0]     wr_ptr_plus1;
  logic [gnmc_pkg::QCNT_W-1:0]     count_next;

  assign wr_ptr_plus1 = wr_ptr + gnmc_pkg::QPTR_W'(1);
  assign head_valid   = (count != '0);
  assign head_data    = entries[rd_ptr];
  assign room_for_two = (count <= gnmc_pkg::QCNT_W'(gnmc_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    count_next = count + gnmc_pkg::QCNT_W'(push0) + gnmc_pkg::QCNT_W'(push1)
               - gnmc_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      entries[wr_ptr] <= push0_data;
    end
    if (push1) begin
      entries[wr_ptr_plus1] <= push1_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + gnmc_pkg::QPTR_W'(push0) + gnmc_pkg::QPTR_W'(push1);
      if (pop) begin
        rd_ptr <= rd_ptr + gnmc_pkg::QPTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// File: design/gnmc_emitter.sv
// ----------------------------------------------------------------------------
// gnmc_emitter
// Lane array computes a whole row of cell values at once; the merge stage
// then walks the columns and drives one result per cycle while m_tready allows.
// ----------------------------------------------------------------------------
`default_nettype none

module gnmc_emitter #(
  parameter int MAX_COLS = 32,
  parameter int COL_W    = 5
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              job_valid,
  input  wire logic [MAX_COLS-1:0]               job_above,
  input  wire logic [MAX_COLS-1:0]               job_mid,
  input  wire logic [MAX_COLS-1:0]               job_below,
  input  wire logic [COL_W-1:0]                  job_last_col,
  input  wire logic                              job_field_end,
  output logic                                   job_pop,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [gnmc_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [3:0] cell_value, [8:4] column
  output logic                                   m_tlast,   // end_of_row
  output logic                                   m_tuser    // end_of_field
);

  logic [MAX_COLS+1:0]           pad_above;
  logic [MAX_COLS+1:0]           pad_mid;
  logic [MAX_COLS+1:0]           pad_below;
  logic [gnmc_pkg::VALUE_W-1:0]  lane_value [MAX_COLS];
  logic [gnmc_pkg::VALUE_W-1:0]  vals [MAX_COLS];
  logic                          busy;
  logic [COL_W-1:0]              col;
  logic [COL_W-1:0]              last_col;
  logic                          field_end;
  logic [gnmc_pkg::VALUE_W-1:0]  out_value;
  logic [gnmc_pkg::COLUMN_W-1:0] out_column;
  logic                          out_free;
  logic                          issue;
  logic                          at_last;
  logic                          load;

  // zero columns on both sides stand for cells outside the grid
  assign pad_above = {1'b0, job_above, 1'b0};
  assign pad_mid   = {1'b0, job_mid, 1'b0};
  assign pad_below = {1'b0, job_below, 1'b0};

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    gnmc_lane u_lane (
      .above (pad_above[c+2:c]),
      .mid   (pad_mid[c+2:c]),
      .below (pad_below[c+2:c]),
      .value (lane_value[c])
    );
  end

  assign out_free = !m_tvalid || m_tready;
  assign issue    = busy && out_free;
  assign at_last  = (col == last_col);
  assign load     = job_valid && (!busy || (issue && at_last));
  assign job_pop  = load;

  assign m_tdata = {(gnmc_pkg::OUT_TDATA_W - gnmc_pkg::VALUE_W - gnmc_pkg::COLUMN_W)'(0),
                    out_column, out_value};

  always_ff @(posedge clk) begin
    if (load) begin
      vals      <= lane_value;
      last_col  <= job_last_col;
      field_end <= job_field_end;
    end
    if (issue) begin
      out_value  <= vals[col];
      out_column <= gnmc_pkg::COLUMN_W'(col);
      m_tlast    <= at_last;
      m_tuser    <= at_last && field_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      col      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_free) begin
        m_tvalid <= issue;
      end
      if (load) begin
        busy <= 1'b1;
        col  <= '0;
      end else if (issue && at_last) begin
        busy <= 1'b0;
      end else if (issue) begin
        col <= col + COL_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: design/grid_neighbor_mine_count.sv
// ----------------------------------------------------------------------------
// grid_neighbor_mine_count
// Minesweeper neighbor counts for a mine grid streamed one row per transaction.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                           | contents
//  s_*      | in  | s_tvalid s_tready s_tdata s_tlast | row_bits, last_row
//  m_*      | out | m_tvalid m_tready m_tdata m_tlast | cell_value, column,
//           |     | m_tuser                           | end_of_row, end_of_field
//  cfg_*    | in  | cfg_wr_en cfg_wr_data             | cols_in_use
//
//  one result per cycle while m_tready allows; a row of n columns gives n results,
//  the last row of a field up to 2n (the pending row plus its own)
//  all lanes evaluate a row at once; the serializing output register sets the rate
//  a job queue of four rows decouples input from output; s_tready drops
//  while fewer than two queue slots are free
//  rst is synchronous: clears stored rows, queue, output valid, cols_in_use to 32
// ----------------------------------------------------------------------------
`default_nettype none

module grid_neighbor_mine_count #(
  parameter int MAX_COLS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [gnmc_pkg::CFG_W-1:0]        cfg_wr_data,  // cols_in_use
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  input  wire logic [gnmc_pkg::ROW_W-1:0]        s_tdata,      // [31:0] row_bits
  input  wire logic                              s_tlast,      // last_row
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  output logic      [gnmc_pkg::OUT_TDATA_W-1:0]  m_tdata,      // [3:0] cell_value, [8:4] column
  output logic                                   m_tlast,      // end_of_row
  output logic                                   m_tuser       // end_of_field
);

  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int JOB_W = 3 * MAX_COLS + COL_W + 1;

  logic [gnmc_pkg::CFG_W-1:0] cols_in_use;
  logic [MAX_COLS-1:0]        row_above;
  logic [MAX_COLS-1:0]        row_middle;
  logic                       middle_valid;

  logic [COL_W-1:0]           last_col;
  logic [MAX_COLS-1:0]        col_mask;
  logic [MAX_COLS-1:0]        cur;
  logic [MAX_COLS-1:0]        above;
  logic [MAX_COLS-1:0]        mid;
  logic                       accept;
  logic [JOB_W-1:0]           job_pending;
  logic [JOB_W-1:0]           job_own;
  logic                       push0;
  logic                       push1;
  logic [JOB_W-1:0]           push0_data;
  logic                       head_valid;
  logic [JOB_W-1:0]           head_data;
  logic                       room_for_two;
  logic                       job_pop;

  // width clamp: zero acts as one column, beyond MAX_COLS as MAX_COLS
  always_comb begin
    priority if (cols_in_use == '0) begin
      last_col = '0;
    end else if (cols_in_use > gnmc_pkg::CFG_W'(MAX_COLS)) begin
      last_col = COL_W'(MAX_COLS - 1);
    end else begin
      last_col = COL_W'(cols_in_use - gnmc_pkg::CFG_W'(1));
    end
    for (int c = 0; c < MAX_COLS; c++) begin
      col_mask[c] = (COL_W'(c) <= last_col);
    end
  end

  assign cur    = s_tdata[MAX_COLS-1:0] & col_mask;
  assign above  = row_above & col_mask;
  assign mid    = row_middle & col_mask;
  assign accept = s_tvalid && s_tready;

  // job layout: field_end, last_col, below, mid, above
  assign job_pending = {1'b0, last_col, cur, mid, above};
  assign job_own     = {1'b1, last_col, MAX_COLS'(0), cur,
                        middle_valid ? mid : MAX_COLS'(0)};

  assign push0      = accept && (middle_valid || s_tlast);
  assign push1      = accept && middle_valid && s_tlast;
  assign push0_data = middle_valid ? job_pending : job_own;
  assign s_tready   = room_for_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use  <= gnmc_pkg::COLS_RESET;
      row_above    <= '0;
      row_middle   <= '0;
      middle_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cols_in_use <= cfg_wr_data;
      end
      if (accept) begin
        if (s_tlast) begin
          row_above    <= '0;
          row_middle   <= '0;
          middle_valid <= 1'b0;
        end else begin
          row_above    <= middle_valid ? mid : '0;
          row_middle   <= cur;
          middle_valid <= 1'b1;
        end
      end
    end
  end

  gnmc_job_queue #(
    .WIDTH (JOB_W)
  ) u_queue (
    .clk          (clk),
    .rst          (rst),
    .push0        (push0),
    .push0_data   (push0_data),
    .push1        (push1),
    .push1_data   (job_own),
    .pop          (job_pop),
    .head_valid   (head_valid),
    .head_data    (head_data),
    .room_for_two (room_for_two)
  );

  gnmc_emitter #(
    .MAX_COLS (MAX_COLS),
    .COL_W    (COL_W)
  ) u_emitter (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (head_valid),
    .job_above     (head_data[MAX_COLS-1:0]),
    .job_mid       (head_data[2*MAX_COLS-1:MAX_COLS]),
    .job_below     (head_data[3*MAX_COLS-1:2*MAX_COLS]),
    .job_last_col  (head_data[3*MAX_COLS+COL_W-1:3*MAX_COLS]),
    .job_field_end (head_data[JOB_W-1]),
    .job_pop       (job_pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .m_tuser       (m_tuser)
  );

endmodule

`default_nettype wire
